// ===== hw/rtl/tpb_pkg.sv =====
// ----------------------------------------------------------------------------
// tpb_pkg: shared types and constants of the tile pixel buffer
// Command codes, register indexes, payload structs and the byte swap used
// by the fill, corner fill and background writes into the pixel store.
// ----------------------------------------------------------------------------
package tpb_pkg;

    // default tile edge, as log2 of the pixel count per row
    localparam int TILE_SIZE_LOG2_DEF = 4;

    // output queue depth (log2)
    localparam int OUTQ_AW = 2;

    // command codes
    localparam logic [1:0] CMD_FILL    = 2'd0;
    localparam logic [1:0] CMD_FILL_BG = 2'd1;
    localparam logic [1:0] CMD_RECT    = 2'd2;
    localparam logic [1:0] CMD_READ    = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH    = 2'd1;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [15:0]        color;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic [3:0]         row_index;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pixel;
        logic [3:0]  column;
        logic        last;
    } t_out_item;

    // read request that travels alongside a store read
    typedef struct packed {
        logic       valid;
        logic [3:0] column;
        logic       last;
    } t_rd_req;

    // output queue status back to the sequencer
    typedef struct packed {
        logic credit_ok;
        logic full;
        logic push;
        logic pop;
    } t_q_status;

    function automatic logic [15:0] swap_bytes(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

endpackage

// ===== hw/rtl/tpb_ram.sv =====
// ----------------------------------------------------------------------------
// tpb_ram: generic simple dual-port RAM
// One write port, one read port with registered data (read-first).
// ----------------------------------------------------------------------------
module tpb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tpb_seq.sv =====
// ----------------------------------------------------------------------------
// tpb_seq: command sequencer and address walker
// One shared x/y incrementer with end compare walks the store for fills,
// corner fills, the post-reset clearing pass and row reads.
// ----------------------------------------------------------------------------
module tpb_seq #(
    parameter int TILE_SIZE_LOG2 = tpb_pkg::TILE_SIZE_LOG2_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  tpb_pkg::t_in_item            i_in_item,
    output logic                         o_in_stall,
    input  logic [15:0]                  i_bg_stored,
    input  logic                         i_refresh,
    input  tpb_pkg::t_q_status           i_q_status,
    output tpb_pkg::t_rd_req             o_rd_req,
    output logic                         o_ram_we,
    output logic [2*TILE_SIZE_LOG2-1:0]  o_ram_waddr,
    output logic [15:0]                  o_ram_wdata,
    output logic                         o_ram_re,
    output logic [2*TILE_SIZE_LOG2-1:0]  o_ram_raddr
);

    localparam int TW = TILE_SIZE_LOG2;
    localparam logic [TW-1:0] TMAX = {TW{1'b1}};

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [TW-1:0] r_x, n_x;
    logic [TW-1:0] r_y, n_y;
    logic [TW-1:0] r_x0, n_x0;
    logic [TW-1:0] r_x1, n_x1;
    logic [TW-1:0] r_y1, n_y1;
    logic [15:0]   r_wdata, n_wdata;

    logic          accept;
    logic          x_end;
    logic          y_end;
    logic          issue;
    logic [15:0]   dx_m1;
    logic [15:0]   dy_m1;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    // shared end compare
    assign x_end = (r_x == r_x1);
    assign y_end = (r_y == r_y1);
    assign issue = (r_state == ST_READ) && i_q_status.credit_ok;

    assign dx_m1 = i_in_item.delta_x - 16'sd1;
    assign dy_m1 = i_in_item.delta_y - 16'sd1;

    // next-state and walker
    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_x0    = r_x0;
        n_x1    = r_x1;
        n_y1    = r_y1;
        n_wdata = r_wdata;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_x  = '0;
                    n_y  = '0;
                    n_x0 = '0;
                    n_x1 = TMAX;
                    n_y1 = TMAX;
                    case (i_in_item.cmd)
                        tpb_pkg::CMD_FILL: begin
                            n_wdata = tpb_pkg::swap_bytes(i_in_item.color);
                            n_state = ST_WALK;
                        end
                        tpb_pkg::CMD_FILL_BG: begin
                            n_wdata = i_bg_stored;
                            n_state = ST_WALK;
                        end
                        tpb_pkg::CMD_RECT: begin
                            n_wdata = tpb_pkg::swap_bytes(i_in_item.color);
                            // columns: left span for positive, right span for negative
                            if (i_in_item.delta_x[15]) begin
                                n_x0 = i_in_item.delta_x[TW-1:0];
                                n_x1 = TMAX;
                            end else begin
                                n_x0 = '0;
                                n_x1 = dx_m1[TW-1:0];
                            end
                            if (i_in_item.delta_y[15]) begin
                                n_y  = i_in_item.delta_y[TW-1:0];
                                n_y1 = TMAX;
                            end else begin
                                n_y  = '0;
                                n_y1 = dy_m1[TW-1:0];
                            end
                            n_x = n_x0;
                            // zero extent leaves the store alone
                            if ((i_in_item.delta_x != 16'sd0) && (i_in_item.delta_y != 16'sd0)) begin
                                n_state = ST_WALK;
                            end
                        end
                        tpb_pkg::CMD_READ: begin
                            n_y     = TW'(i_in_item.row_index);
                            n_state = ST_READ;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (x_end) begin
                    n_x = r_x0;
                    n_y = r_y + 1'b1;
                    if (y_end) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_x = r_x + 1'b1;
                end
            end
            ST_READ: begin
                if (issue) begin
                    n_x = r_x + 1'b1;
                    if (x_end) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state registers; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WALK;
            r_x     <= '0;
            r_y     <= '0;
            r_x0    <= '0;
            r_x1    <= TMAX;
            r_y1    <= TMAX;
            r_wdata <= '0;
        end else begin
            r_state <= n_state;
            r_x     <= n_x;
            r_y     <= n_y;
            r_x0    <= n_x0;
            r_x1    <= n_x1;
            r_y1    <= n_y1;
            r_wdata <= n_wdata;
        end
    end

    // store access; a refresh write lands on the address being read
    always_comb begin
        o_ram_re    = issue;
        o_ram_raddr = {r_y, r_x};
        o_ram_waddr = {r_y, r_x};
        if (r_state == ST_READ) begin
            o_ram_we    = issue && i_refresh;
            o_ram_wdata = i_bg_stored;
        end else begin
            o_ram_we    = (r_state == ST_WALK);
            o_ram_wdata = r_wdata;
        end
    end

    assign o_rd_req.valid  = issue;
    assign o_rd_req.column = 4'(r_x);
    assign o_rd_req.last   = x_end;

endmodule

// ===== hw/rtl/tpb_outq.sv =====
// ----------------------------------------------------------------------------
// tpb_outq: result queue
// Catches store read data in the cycle after the read and holds results until
// the receiver takes them; grants read credits to the sequencer.
// ----------------------------------------------------------------------------
module tpb_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tpb_pkg::t_rd_req    i_rd_req,
    input  logic [15:0]         i_rdata,
    output tpb_pkg::t_q_status  o_status,
    output logic                o_out_valid,
    output tpb_pkg::t_out_item  o_out_item,
    input  logic                i_out_stall
);

    localparam int QAW   = tpb_pkg::OUTQ_AW;
    localparam int QD    = 1 << QAW;
    localparam int CW    = QAW + 1;

    tpb_pkg::t_rd_req   r_req;
    tpb_pkg::t_out_item r_slot [QD];
    logic [QAW-1:0]     r_wptr;
    logic [QAW-1:0]     r_rptr;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [CW-1:0]      committed;
    logic               push;
    logic               pop;

    assign push      = r_req.valid;
    assign pop       = o_out_valid && !i_out_stall;
    assign committed = r_count + CW'(r_req.valid);

    // read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.valid <= 1'b0;
        end else begin
            r_req.valid <= i_rd_req.valid;
        end
        r_req.column <= i_rd_req.column;
        r_req.last   <= i_rd_req.last;
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= '{pixel: i_rdata, column: r_req.column, last: r_req.last};
        end
    end

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    assign o_out_valid        = (r_count != '0);
    assign o_out_item         = r_slot[r_rptr];
    assign o_status.credit_ok = (committed < CW'(QD));
    assign o_status.full      = (r_count == CW'(QD));
    assign o_status.push      = push;
    assign o_status.pop       = pop;

endmodule

// ===== hw/rtl/tile_pixel_buffer_core.sv =====
// ----------------------------------------------------------------------------
// tile_pixel_buffer_core: square tile pixel store with clear-on-read
// Holds L x L byte-swapped 16-bit colors (L = 2**TILE_SIZE_LOG2) and runs
// fill, background fill, corner fill and row read commands.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_stall / i_in_item): one command per
//    item. o_in_stall is high while a command is running.
//  - Output channel (o_out_valid / i_out_stall / o_out_item): a row read
//    returns L items, column order, last set on the final one. Fills return
//    nothing.
//  - Config channel (i_cfg_valid / o_cfg_ready): index 0 background color,
//    index 1 refresh enable; write only when the block is idle.
//  - Timing: a fill or corner fill walks its area once; a zero-extent corner
//    fill writes nothing. A row read issues one store read per cycle while the
//    queue has a free credit; each item passes the store's read register and a
//    queue slot before it is out. The pace is set by the single store port and the one address walker.
//  - Results wait in a 4-deep queue; a stalled receiver holds the head item
//    and read issue pauses once the queue has no free credit. The next
//    command can be taken while results of a read are still queued.
//  - Reset: the sequencer walks the whole store writing zero, with o_in_stall
//    high; config writes are still taken.
// ----------------------------------------------------------------------------
module tile_pixel_buffer_core #(
    parameter int TILE_SIZE_LOG2 = tpb_pkg::TILE_SIZE_LOG2_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  tpb_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output tpb_pkg::t_out_item                o_out_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tpb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [15:0]                       i_cfg_data
);

    localparam int AW = 2 * TILE_SIZE_LOG2;

    logic [15:0]        r_background;
    logic               r_refresh;
    logic [15:0]        bg_stored;
    tpb_pkg::t_q_status q_status;
    tpb_pkg::t_rd_req   rd_req;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [15:0]        ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [15:0]        ram_rdata;
    logic               in_accept;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_background <= '0;
            r_refresh    <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tpb_pkg::CFG_BACKGROUND: r_background <= i_cfg_data;
                tpb_pkg::CFG_REFRESH:    r_refresh    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign bg_stored = tpb_pkg::swap_bytes(r_background);
    assign in_accept = i_in_valid && !o_in_stall;

    tpb_seq #(
        .TILE_SIZE_LOG2 (TILE_SIZE_LOG2)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .i_bg_stored (bg_stored),
        .i_refresh   (r_refresh),
        .i_q_status  (q_status),
        .o_rd_req    (rd_req),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr)
    );

    tpb_ram #(
        .WIDTH (16),
        .DEPTH (1 << AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tpb_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_req    (rd_req),
        .i_rdata     (ram_rdata),
        .o_status    (q_status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    // queue never overflows
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.push && q_status.full |-> q_status.pop)
        else $error("result queue overflow");

    // a store read is only issued against a free queue credit
    a_read_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_req.valid |-> q_status.credit_ok)
        else $error("read issued without credit");

    // every command other than a corner fill, which may have zero extent, keeps the block busy afterwards
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (i_in_item.cmd != tpb_pkg::CMD_RECT) |=> o_in_stall)
        else $error("command accepted without running");

endmodule
